FILE: design/tsgt_pkg.sv
// ----------------------------------------------------------------------------
// Touch swipe gesture tracker package
// Shared payload types, swipe direction codes and backlight level constants.
// ----------------------------------------------------------------------------
package tsgt_pkg;

  // Widths of the payload fields as they appear on the ports.
  localparam int unsigned PosBits      = 12;
  localparam int unsigned LevelBits    = 8;
  localparam int unsigned ThreshBits   = 8;
  // Widest supported internal coordinate.
  localparam int unsigned CoordMaxBits = 15;

  // Reset value of the swipe threshold register.
  localparam logic [ThreshBits-1:0] ThreshReset = 8'd120;

  // Backlight level ladder.
  localparam logic [LevelBits-1:0] LevelFull  = 8'd255;
  localparam logic [LevelBits-1:0] LevelStep1 = 8'd128;
  localparam logic [LevelBits-1:0] LevelStep2 = 8'd96;
  localparam logic [LevelBits-1:0] LevelStep3 = 8'd64;
  localparam logic [LevelBits-1:0] LevelStep4 = 8'd32;
  localparam logic [LevelBits-1:0] LevelMin   = 8'd16;
  localparam logic [LevelBits-1:0] LevelOff   = 8'd0;

  // Excess bounds that separate the rungs of the ladder.
  localparam logic [7:0] ExcessBound1 = 8'd25;
  localparam logic [7:0] ExcessBound2 = 8'd50;
  localparam logic [7:0] ExcessBound3 = 8'd75;
  localparam logic [7:0] ExcessBound4 = 8'd100;

  // Swipe direction reported on release.
  typedef enum logic [2:0] {
    SwipeNone  = 3'd0,
    SwipeRight = 3'd1,
    SwipeLeft  = 3'd2,
    SwipeDown  = 3'd3,
    SwipeUp    = 3'd4
  } swipe_e;

  // One polled touch sample.
  typedef struct packed {
    logic               pressed;
    logic [PosBits-1:0] pos_x;
    logic [PosBits-1:0] pos_y;
  } tsgt_in_t;

  // One result item.
  typedef struct packed {
    logic                 touch_start;
    logic                 touch_release;
    logic                 user_activity;
    logic                 level_valid;
    logic [LevelBits-1:0] backlight_level;
    swipe_e               swipe;
  } tsgt_out_t;

endpackage

FILE: design/tsgt_tracker.sv
// ----------------------------------------------------------------------------
// Touch swipe gesture tracker: press state and evaluation
// Holds the start and latest point of the current press and evaluates one
// sample per cycle into a result item, updating the press state on process_i.
// ----------------------------------------------------------------------------
module tsgt_tracker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            process_i,
  input  logic [tsgt_pkg::ThreshBits-1:0] threshold_i,
  input  tsgt_pkg::tsgt_in_t              sample_i,
  output tsgt_pkg::tsgt_out_t             result_o
);

  localparam int unsigned CW = COORD_BITS;

  logic          press_active_q, press_active_d;
  logic [CW-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic [CW-1:0] latest_x_q, latest_x_d, latest_y_q, latest_y_d;

  logic [tsgt_pkg::CoordMaxBits-1:0] x_ext, y_ext;
  logic [CW-1:0] x_c, y_c;
  logic [CW-1:0] cur_x, cur_y;
  logic          x_gt, y_gt;
  logic [CW-1:0] ax, ay, mag, excess, thr_w;
  logic [tsgt_pkg::LevelBits-1:0] move_level;
  tsgt_pkg::swipe_e               dir;

  // Coordinates are taken modulo the internal coordinate width.
  assign x_ext = tsgt_pkg::CoordMaxBits'(sample_i.pos_x);
  assign y_ext = tsgt_pkg::CoordMaxBits'(sample_i.pos_y);
  assign x_c   = x_ext[CW-1:0];
  assign y_c   = y_ext[CW-1:0];
  assign thr_w = CW'(threshold_i);

  // A pressed sample measures from its own point, a release from the latest one.
  assign cur_x = sample_i.pressed ? x_c : latest_x_q;
  assign cur_y = sample_i.pressed ? y_c : latest_y_q;

  // Absolute displacement along each axis.
  assign x_gt = cur_x > start_x_q;
  assign y_gt = cur_y > start_y_q;
  assign ax   = x_gt ? (cur_x - start_x_q) : (start_x_q - cur_x);
  assign ay   = y_gt ? (cur_y - start_y_q) : (start_y_q - cur_y);
  assign mag  = (ax > ay) ? ax : ay;

  // Backlight level falls as the swipe grows past the threshold.
  assign excess = mag - thr_w;
  always_comb begin
    priority if (mag <= thr_w) begin
      move_level = tsgt_pkg::LevelFull;
    end else if (excess < CW'(tsgt_pkg::ExcessBound1)) begin
      move_level = tsgt_pkg::LevelStep1;
    end else if (excess < CW'(tsgt_pkg::ExcessBound2)) begin
      move_level = tsgt_pkg::LevelStep2;
    end else if (excess < CW'(tsgt_pkg::ExcessBound3)) begin
      move_level = tsgt_pkg::LevelStep3;
    end else if (excess < CW'(tsgt_pkg::ExcessBound4)) begin
      move_level = tsgt_pkg::LevelStep4;
    end else begin
      move_level = tsgt_pkg::LevelMin;
    end
  end

  // Direction on release; a tie between the axes goes to the vertical one.
  always_comb begin
    priority if ((ax < thr_w) && (ay < thr_w)) begin
      dir = tsgt_pkg::SwipeNone;
    end else if (ax > ay) begin
      dir = x_gt ? tsgt_pkg::SwipeRight : tsgt_pkg::SwipeLeft;
    end else begin
      dir = y_gt ? tsgt_pkg::SwipeDown : tsgt_pkg::SwipeUp;
    end
  end

  // Result item and next press state.
  always_comb begin
    result_o       = '0;
    result_o.swipe = tsgt_pkg::SwipeNone;
    press_active_d = press_active_q;
    start_x_d      = start_x_q;
    start_y_d      = start_y_q;
    latest_x_d     = latest_x_q;
    latest_y_d     = latest_y_q;
    if (sample_i.pressed) begin
      result_o.user_activity = 1'b1;
      latest_x_d             = x_c;
      latest_y_d             = y_c;
      if (!press_active_q) begin
        press_active_d       = 1'b1;
        start_x_d            = x_c;
        start_y_d            = y_c;
        result_o.touch_start = 1'b1;
      end else begin
        result_o.level_valid     = 1'b1;
        result_o.backlight_level = move_level;
      end
    end else if (press_active_q) begin
      press_active_d           = 1'b0;
      result_o.touch_release   = 1'b1;
      result_o.user_activity   = 1'b1;
      result_o.level_valid     = 1'b1;
      result_o.backlight_level = tsgt_pkg::LevelFull;
      result_o.swipe           = dir;
    end else begin
      result_o.backlight_level = tsgt_pkg::LevelOff;
    end
  end

  // Press state advances only when a sample is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_active_q <= 1'b0;
      start_x_q      <= '0;
      start_y_q      <= '0;
      latest_x_q     <= '0;
      latest_y_q     <= '0;
    end else if (process_i) begin
      press_active_q <= press_active_d;
      start_x_q      <= start_x_d;
      start_y_q      <= start_y_d;
      latest_x_q     <= latest_x_d;
      latest_y_q     <= latest_y_d;
    end
  end

endmodule

FILE: design/touch_swipe_gesture_tracker_core.sv
// ----------------------------------------------------------------------------
// Touch swipe gesture tracker core
// Turns polled touch samples into touch start, release, backlight level and
// swipe direction results.
// ----------------------------------------------------------------------------
// The core accepts one touch sample per clock cycle while results are taken,
// and returns exactly one result per sample, in sample order: the sample
// is captured in an input register, evaluated by a single pass of compare and
// subtract logic against the current press state, and held in a result
// register until the consumer takes it. While the result register is full
// and not being taken, the input register fills and then in_ready_o drops.
// The swipe threshold is written through cfg_we_i/cfg_wdata_i and resets to
// 120; write it only while no sample is in flight.
module touch_swipe_gesture_tracker_core #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tsgt_pkg::tsgt_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tsgt_pkg::tsgt_out_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [tsgt_pkg::ThreshBits-1:0] cfg_wdata_i
);

  logic [tsgt_pkg::ThreshBits-1:0] threshold_q;
  logic                            in_valid_q, in_valid_d;
  tsgt_pkg::tsgt_in_t              in_data_q;
  logic                            out_valid_q, out_valid_d;
  tsgt_pkg::tsgt_out_t             out_data_q;
  tsgt_pkg::tsgt_out_t             result;
  logic                            advance;
  logic                            in_xfer;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= tsgt_pkg::ThreshReset;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  // A sample moves to the result register when that register is free or emptying.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Input register.
  assign in_valid_d = in_xfer || (in_valid_q && !advance);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_data_q <= in_data_i;
    end
  end

  // Evaluation and press state.
  tsgt_tracker #(
    .COORD_BITS(COORD_BITS)
  ) u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .process_i  (advance),
    .threshold_i(threshold_q),
    .sample_i   (in_data_q),
    .result_o   (result)
  );

  // Result register.
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A press cannot start and end on the same sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.touch_start && out_data_o.touch_release))
    else $error("touch start and release reported together");

  // A direction is only reported on a release.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.swipe != tsgt_pkg::SwipeNone)) |->
      out_data_o.touch_release)
    else $error("swipe reported without release");

  // Without a new level the level field is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.level_valid) |->
      (out_data_o.backlight_level == tsgt_pkg::LevelOff))
    else $error("level field set without level_valid");

  // A release restores full brightness and counts as activity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.touch_release) |->
      (out_data_o.user_activity && out_data_o.level_valid &&
       (out_data_o.backlight_level == tsgt_pkg::LevelFull)))
    else $error("release without full brightness");

endmodule

FILE: dv/tb_touch_swipe_gesture_tracker_core.sv
// ----------------------------------------------------------------------------
// Touch swipe gesture tracker core testbench
// Feeds touch samples as directed presses and random gestures. Each sample is
// run through a local gesture predictor, and every result transfer is checked
// in order against the predicted result.
// ----------------------------------------------------------------------------
module tb_touch_swipe_gesture_tracker_core;

  // Predicts the result of each accepted sample and checks results in order.
  class gesture_scoreboard;
    logic [tsgt_pkg::ThreshBits-1:0] threshold;
    bit                              press_active;
    int                              start_x, start_y, latest_x, latest_y;
    tsgt_pkg::tsgt_out_t             pending_gestures[$];
    int                              failures;

    function new();
      threshold    = tsgt_pkg::ThreshReset;
      press_active = 1'b0;
      start_x      = 0;
      start_y      = 0;
      latest_x     = 0;
      latest_y     = 0;
      failures     = 0;
    endfunction

    // Updates the press state for one accepted sample and queues its result.
    function void predict_gesture(tsgt_pkg::tsgt_in_t s);
      tsgt_pkg::tsgt_out_t exp;
      int                  ax, ay, span, excess;
      exp       = '0;
      exp.swipe = tsgt_pkg::SwipeNone;
      if (s.pressed) begin
        latest_x = s.pos_x;
        latest_y = s.pos_y;
      end
      ax = (latest_x > start_x) ? latest_x - start_x : start_x - latest_x;
      ay = (latest_y > start_y) ? latest_y - start_y : start_y - latest_y;
      if (s.pressed) begin
        exp.user_activity = 1'b1;
        if (!press_active) begin
          press_active    = 1'b1;
          start_x         = s.pos_x;
          start_y         = s.pos_y;
          exp.touch_start = 1'b1;
        end else begin
          exp.level_valid = 1'b1;
          span = (ax > ay) ? ax : ay;
          if (span <= int'(threshold)) begin
            exp.backlight_level = tsgt_pkg::LevelFull;
          end else begin
            excess = span - int'(threshold);
            if (excess < int'(tsgt_pkg::ExcessBound1)) begin
              exp.backlight_level = tsgt_pkg::LevelStep1;
            end else if (excess < int'(tsgt_pkg::ExcessBound2)) begin
              exp.backlight_level = tsgt_pkg::LevelStep2;
            end else if (excess < int'(tsgt_pkg::ExcessBound3)) begin
              exp.backlight_level = tsgt_pkg::LevelStep3;
            end else if (excess < int'(tsgt_pkg::ExcessBound4)) begin
              exp.backlight_level = tsgt_pkg::LevelStep4;
            end else begin
              exp.backlight_level = tsgt_pkg::LevelMin;
            end
          end
        end
      end else if (press_active) begin
        // A tie between the axes goes to the vertical direction.
        if (ax < int'(threshold) && ay < int'(threshold)) begin
          exp.swipe = tsgt_pkg::SwipeNone;
        end else if (ax > ay) begin
          exp.swipe = (latest_x > start_x) ? tsgt_pkg::SwipeRight : tsgt_pkg::SwipeLeft;
        end else begin
          exp.swipe = (latest_y > start_y) ? tsgt_pkg::SwipeDown : tsgt_pkg::SwipeUp;
        end
        press_active        = 1'b0;
        exp.touch_release   = 1'b1;
        exp.user_activity   = 1'b1;
        exp.level_valid     = 1'b1;
        exp.backlight_level = tsgt_pkg::LevelFull;
      end
      pending_gestures.push_back(exp);
    endfunction

    // Compares one result transfer with the oldest predicted result.
    function void check_gesture(tsgt_pkg::tsgt_out_t got);
      tsgt_pkg::tsgt_out_t exp;
      if (pending_gestures.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("ERROR: result transfer with no sample outstanding at %0t", $realtime);
        end
        return;
      end
      exp = pending_gestures.pop_front();
      if (got.touch_start !== exp.touch_start || got.touch_release !== exp.touch_release ||
          got.user_activity !== exp.user_activity || got.level_valid !== exp.level_valid ||
          got.backlight_level !== exp.backlight_level || got.swipe !== exp.swipe) begin
        failures++;
        if (failures <= 10) begin
          $display("ERROR: result mismatch at %0t", $realtime);
          $display("  expected start=%0b release=%0b activity=%0b lv=%0b level=%0d swipe=%0d",
                   exp.touch_start, exp.touch_release, exp.user_activity, exp.level_valid,
                   exp.backlight_level, exp.swipe);
          $display("  actual   start=%0b release=%0b activity=%0b lv=%0b level=%0d swipe=%0d",
                   got.touch_start, got.touch_release, got.user_activity, got.level_valid,
                   got.backlight_level, got.swipe);
        end
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  tsgt_pkg::tsgt_in_t              in_data_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  tsgt_pkg::tsgt_out_t             out_data_o;
  logic                            cfg_we_i;
  logic [tsgt_pkg::ThreshBits-1:0] cfg_wdata_i;

  gesture_scoreboard sb = new();
  bit                idle_on = 1'b1;
  int                hold_cycles_req = 0;
  int                items_sent = 0;

  touch_swipe_gesture_tracker_core #(
    .COORD_BITS(12)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Clock with a period of 4 time units.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Observe both channels at the rising edge.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) sb.predict_gesture(in_data_i);
    if (out_valid_o && out_ready_i) sb.check_gesture(out_data_o);
  end

  // Builds a touch sample, clamping coordinates to the screen.
  function automatic tsgt_pkg::tsgt_in_t touch(logic pressed, int x, int y);
    tsgt_pkg::tsgt_in_t s;
    s.pressed = pressed;
    s.pos_x   = (x < 0) ? '0 : (x > 4095) ? 12'd4095 : x[tsgt_pkg::PosBits-1:0];
    s.pos_y   = (y < 0) ? '0 : (y > 4095) ? 12'd4095 : y[tsgt_pkg::PosBits-1:0];
    return s;
  endfunction

  // Offers one sample after a random gap; entered and left at a falling edge.
  task automatic send_sample(input tsgt_pkg::tsgt_in_t s);
    int gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    for (int i = 0; i < 5000 && sb.pending_gestures.size() != 0; i++) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_threshold(input logic [tsgt_pkg::ThreshBits-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    sb.threshold = value;
  endtask

  // Mostly complete press, move and release sequences, plus noise and
  // presses that never see a release.
  task automatic run_gestures(input int n_items);
    int stop_at, kind, moves, reach, sx, sy, dx, dy;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      kind  = $urandom_range(0, 19);
      reach = int'(sb.threshold) + 130;
      if ($urandom_range(0, 7) == 0) idle_on = !idle_on;
      if (kind == 0) begin
        send_sample(touch(1'($urandom_range(0, 1)), $urandom_range(0, 4095),
                          $urandom_range(0, 4095)));
      end else if (kind == 1) begin
        send_sample(touch(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095)));
      end else begin
        sx = ($urandom_range(0, 5) == 0) ? 4095 * $urandom_range(0, 1)
                                         : $urandom_range(0, 4095);
        sy = ($urandom_range(0, 5) == 0) ? 4095 * $urandom_range(0, 1)
                                         : $urandom_range(0, 4095);
        send_sample(touch(1'b1, sx, sy));
        moves = $urandom_range(0, 5);
        repeat (moves) begin
          dx = int'($urandom_range(0, 2 * reach)) - reach;
          // Equal displacement on both axes now and then to hit the tie rule.
          if ($urandom_range(0, 4) == 0) dy = $urandom_range(0, 1) ? dx : -dx;
          else dy = int'($urandom_range(0, 2 * reach)) - reach;
          send_sample(touch(1'b1, sx + dx, sy + dy));
        end
        if ($urandom_range(0, 9) != 0) begin
          send_sample(touch(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095)));
        end
      end
    end
  endtask

  // Result consumer with random stalls and the occasional long hold-off.
  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles_req > 0) begin
        stall           = hold_cycles_req;
        hold_cycles_req = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, 17) : 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Directed presses, then random gestures under several thresholds.
  initial begin : stimulus
    logic [tsgt_pkg::ThreshBits-1:0] thresholds[6];
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    thresholds  = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd40, tsgt_pkg::ThreshReset};
    thresholds[3] = tsgt_pkg::ThreshBits'($urandom_range(2, 254));
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset threshold: release with no press, then every rung of the ladder.
    send_sample(touch(1'b0, 4095, 4095));
    send_sample(touch(1'b1, 0, 0));
    send_sample(touch(1'b1, 0, 0));
    send_sample(touch(1'b1, 120, 0));
    send_sample(touch(1'b1, 121, 0));
    send_sample(touch(1'b1, 145, 0));
    send_sample(touch(1'b1, 0, 170));
    send_sample(touch(1'b1, 195, 0));
    send_sample(touch(1'b1, 220, 0));
    send_sample(touch(1'b1, 4095, 4095));
    send_sample(touch(1'b0, 0, 0));
    // Motion just under the threshold gives no swipe.
    send_sample(touch(1'b1, 4095, 4095));
    send_sample(touch(1'b1, 3976, 4095));
    send_sample(touch(1'b0, 1234, 2345));
    // One swipe to the left, one up and one to the right, then a press with no motion.
    send_sample(touch(1'b1, 2000, 2000));
    send_sample(touch(1'b1, 1800, 2050));
    send_sample(touch(1'b0, 4095, 0));
    send_sample(touch(1'b1, 1000, 1000));
    send_sample(touch(1'b1, 1000, 700));
    send_sample(touch(1'b0, 0, 4095));
    send_sample(touch(1'b1, 500, 500));
    send_sample(touch(1'b1, 900, 500));
    send_sample(touch(1'b0, 2730, 1365));
    send_sample(touch(1'b1, 10, 10));
    send_sample(touch(1'b0, 10, 10));
    wait_drained();

    foreach (thresholds[phase]) begin
      set_threshold(thresholds[phase]);
      if (thresholds[phase] == 8'd0) begin
        // With a zero threshold, no motion reads as up and a tie as down.
        send_sample(touch(1'b1, 2048, 2048));
        send_sample(touch(1'b1, 2048, 2048));
        send_sample(touch(1'b0, 0, 0));
        send_sample(touch(1'b1, 100, 100));
        send_sample(touch(1'b1, 300, 300));
        send_sample(touch(1'b0, 0, 0));
      end
      if (phase == 1 || phase == 4) begin
        // Long consumer hold-off while samples keep coming, to fill the core.
        idle_on         = 1'b0;
        hold_cycles_req = 300;
      end
      run_gestures(108);
      wait_drained();
    end

    if (sb.failures == 0 && sb.pending_gestures.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit.
  initial begin : watchdog
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sim.f
design/tsgt_pkg.sv
design/tsgt_tracker.sv
design/touch_swipe_gesture_tracker_core.sv
dv/tb_touch_swipe_gesture_tracker_core.sv
